### src/mbrm_pkg.sv
// Shared types, codes and the CRC-16 byte update for the Modbus RTU master.
package mbrm_pkg;

  // Input action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_WORD   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Transaction status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TIMEOUT   = 3'd1;
  localparam logic [2:0] ST_BAD_HDR   = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_CRC   = 3'd4;

  // Result batch modes
  localparam logic [1:0] MODE_TX     = 2'd0;
  localparam logic [1:0] MODE_WORDS  = 2'd1;
  localparam logic [1:0] MODE_STATUS = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_SLAVE_ADDR = 2'd0;
  localparam logic [1:0] REG_FIRST_REG  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT    = 2'd2;

  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [7:0]  FC_READ   = 8'h03;
  localparam logic [7:0]  FC_WRITE  = 8'h06;
  localparam logic [15:0] CLAMP_MAX = 16'd100;
  localparam logic [15:0] QUIET_MAX = 16'hFFFF;
  localparam int          MAX_WORDS = 6;
  localparam int          CLAMP_FROM = 4;
  localparam int          REQ_BODY  = 6;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  first_register;
    logic [15:0] timeout_ms;
  } cfg_t;

  // One run of results, handed from the core to the output sequencer
  typedef struct packed {
    logic [1:0]                 mode;
    logic [2:0]                 st;
    logic [REQ_BODY-1:0][7:0]   req;
  } batch_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### src/mbrm_cfg.sv
// APB-style configuration registers of the Modbus RTU master.
module mbrm_cfg (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output mbrm_pkg::cfg_t     cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.slave_address  <= 8'd1;
      cfg.first_register <= 8'd0;
      cfg.timeout_ms     <= 16'd100;
    end else if (wr) begin
      case (paddr[3:2])
        mbrm_pkg::REG_SLAVE_ADDR: cfg.slave_address  <= pwdata[7:0];
        mbrm_pkg::REG_FIRST_REG:  cfg.first_register <= pwdata[7:0];
        mbrm_pkg::REG_TIMEOUT:    cfg.timeout_ms     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mbrm_pkg::REG_SLAVE_ADDR: prdata = {24'd0, cfg.slave_address};
      mbrm_pkg::REG_FIRST_REG:  prdata = {24'd0, cfg.first_register};
      mbrm_pkg::REG_TIMEOUT:    prdata = {16'd0, cfg.timeout_ms};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

### src/mbrm_core.sv
// Request input register, transaction state and reply checking of the Modbus master.
module mbrm_core #(
  parameter int NUM_REGS = 6
) (
  input  logic                clk,
  input  logic                rst,
  input  mbrm_pkg::cfg_t      cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          action,
  input  logic [15:0]         target_register,
  input  logic [15:0]         write_value,
  input  logic [7:0]          rx_data,
  input  logic                batch_free,
  output logic                batch_load,
  output mbrm_pkg::batch_t    batch,
  input  logic [2:0]          rd_idx,
  output logic [15:0]         rd_word
);

  localparam int RX_LEN   = 5 + 2 * NUM_REGS;
  localparam int MAX_LEN  = (RX_LEN > 8) ? RX_LEN : 8;
  localparam int POS_W    = $clog2(MAX_LEN);
  localparam int LEN_W    = POS_W + 1;
  localparam int WORD_CNT = (NUM_REGS < mbrm_pkg::MAX_WORDS) ? NUM_REGS : mbrm_pkg::MAX_WORDS;
  localparam int WIDX_W   = (WORD_CNT > 1) ? $clog2(WORD_CNT) : 1;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_READ  = 2'd1;
  localparam logic [1:0] PH_WRITE = 2'd2;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [15:0] s1_treg;
  logic [15:0] s1_wval;
  logic [7:0]  s1_rx;
  logic        fire;

  // transaction state
  logic [1:0]       phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [15:0]      running_crc, running_crc_next;
  logic [7:0]       held_byte, held_byte_next;
  logic             header_error, header_error_next;
  logic             count_error, count_error_next;
  logic [15:0]      quiet_ms, quiet_ms_next;
  logic [15:0]      word_store [WORD_CNT];

  logic              wr_en;
  logic [WIDX_W-1:0] wr_idx;
  logic              load_c;

  assign fire       = s1_valid && batch_free;
  assign in_ready   = !s1_valid || fire;
  assign batch_load = fire && load_c;
  assign rd_word    = word_store[rd_idx[WIDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_treg   <= target_register;
      s1_wval   <= write_value;
      s1_rx     <= rx_data;
    end
  end

  always_comb begin
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] off;
    logic [LEN_W-2:0] w;
    logic [15:0]      q_inc;
    logic [15:0]      got;
    logic [2:0]       st;
    logic             is_read;

    phase_next         = phase;
    byte_position_next = byte_position;
    running_crc_next   = running_crc;
    held_byte_next     = held_byte;
    header_error_next  = header_error;
    count_error_next   = count_error;
    quiet_ms_next      = quiet_ms;
    wr_en              = 1'b0;
    wr_idx             = '0;
    load_c             = 1'b0;
    batch              = '0;

    is_read = (phase == PH_READ);
    len     = is_read ? LEN_W'(RX_LEN) : LEN_W'(8);
    p       = {1'b0, byte_position};
    off     = p - LEN_W'(3);
    w       = off[LEN_W-1:1];
    q_inc   = (quiet_ms != mbrm_pkg::QUIET_MAX) ? quiet_ms + 16'd1 : quiet_ms;
    got     = {s1_rx, held_byte};
    st      = mbrm_pkg::ST_OK;

    if (s1_action == mbrm_pkg::ACT_READ || s1_action == mbrm_pkg::ACT_WRITE) begin
      // new request; any pending transaction is dropped silently
      load_c        = 1'b1;
      batch.mode    = mbrm_pkg::MODE_TX;
      batch.req[0]  = cfg.slave_address;
      if (s1_action == mbrm_pkg::ACT_READ) begin
        batch.req[1] = mbrm_pkg::FC_READ;
        batch.req[2] = 8'h00;
        batch.req[3] = cfg.first_register;
        batch.req[4] = 8'h00;
        batch.req[5] = 8'(NUM_REGS);
        phase_next   = PH_READ;
      end else begin
        batch.req[1] = mbrm_pkg::FC_WRITE;
        batch.req[2] = s1_treg[15:8];
        batch.req[3] = s1_treg[7:0];
        batch.req[4] = s1_wval[15:8];
        batch.req[5] = s1_wval[7:0];
        phase_next   = PH_WRITE;
      end
      byte_position_next = '0;
      running_crc_next   = mbrm_pkg::CRC_INIT;
      held_byte_next     = 8'h00;
      header_error_next  = 1'b0;
      count_error_next   = 1'b0;
      quiet_ms_next      = 16'd0;
    end else if (phase != PH_IDLE) begin
      if (s1_action == mbrm_pkg::ACT_TICK) begin
        quiet_ms_next = q_inc;
        if (q_inc > cfg.timeout_ms) begin
          load_c     = 1'b1;
          batch.mode = mbrm_pkg::MODE_STATUS;
          batch.st   = mbrm_pkg::ST_TIMEOUT;
          phase_next = PH_IDLE;
        end
      end else begin
        quiet_ms_next = 16'd0;
        if (p == LEN_W'(0) && s1_rx != cfg.slave_address) begin
          header_error_next = 1'b1;
        end
        if (p == LEN_W'(1) && s1_rx != (is_read ? mbrm_pkg::FC_READ : mbrm_pkg::FC_WRITE)) begin
          header_error_next = 1'b1;
        end
        if (p + LEN_W'(2) < len) begin
          running_crc_next = mbrm_pkg::crc_byte(running_crc, s1_rx);
        end
        if (is_read && p == LEN_W'(2) && s1_rx != 8'(2 * NUM_REGS)) begin
          count_error_next = 1'b1;
        end
        if (is_read && p >= LEN_W'(3) && p + LEN_W'(2) < len) begin
          if (!off[0]) begin
            held_byte_next = s1_rx;
          end else if ({1'b0, w} < LEN_W'(WORD_CNT)) begin
            wr_en  = 1'b1;
            wr_idx = w[WIDX_W-1:0];
          end
        end
        if (p + LEN_W'(2) == len) begin
          held_byte_next = s1_rx;
        end
        if (p + LEN_W'(1) >= len) begin
          if (header_error) begin
            st = mbrm_pkg::ST_BAD_HDR;
          end else if (is_read && count_error) begin
            st = mbrm_pkg::ST_BAD_COUNT;
          end else if (got != running_crc) begin
            st = mbrm_pkg::ST_BAD_CRC;
          end
          load_c     = 1'b1;
          batch.mode = (st == mbrm_pkg::ST_OK && is_read) ? mbrm_pkg::MODE_WORDS
                                                          : mbrm_pkg::MODE_STATUS;
          batch.st   = st;
          phase_next = PH_IDLE;
          byte_position_next = '0;
        end else begin
          byte_position_next = byte_position + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      byte_position <= '0;
      running_crc   <= mbrm_pkg::CRC_INIT;
      held_byte     <= 8'h00;
      header_error  <= 1'b0;
      count_error   <= 1'b0;
      quiet_ms      <= 16'd0;
    end else if (fire) begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
      running_crc   <= running_crc_next;
      held_byte     <= held_byte_next;
      header_error  <= header_error_next;
      count_error   <= count_error_next;
      quiet_ms      <= quiet_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && wr_en) begin
      word_store[wr_idx] <= {held_byte, s1_rx};
    end
  end

endmodule

### src/mbrm_seq.sv
// Output sequencer: plays one result run out item by item, with the request CRC.
module mbrm_seq #(
  parameter int NUM_REGS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               batch_load,
  input  mbrm_pkg::batch_t   batch,
  output logic               batch_free,
  output logic [2:0]         rd_idx,
  input  logic [15:0]        rd_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [7:0]         tx_data,
  output logic [2:0]         word_index,
  output logic [15:0]        word_value,
  output logic [2:0]         status,
  output logic               last
);

  localparam int WORD_CNT = (NUM_REGS < mbrm_pkg::MAX_WORDS) ? NUM_REGS : mbrm_pkg::MAX_WORDS;

  logic             busy;
  mbrm_pkg::batch_t cur;
  logic [2:0]       pos;
  logic [15:0]      crc;
  logic             take;
  logic [7:0]       body_byte;

  assign out_valid  = busy;
  assign take       = busy && out_ready;
  assign batch_free = !busy || (out_ready && last);
  assign rd_idx     = pos;
  assign body_byte  = cur.req[pos];

  always_comb begin
    kind       = mbrm_pkg::KIND_STATUS;
    tx_data    = 8'h00;
    word_index = 3'd0;
    word_value = 16'd0;
    status     = 3'd0;
    last       = 1'b0;
    case (cur.mode)
      mbrm_pkg::MODE_TX: begin
        kind = mbrm_pkg::KIND_TX;
        if (pos < 3'(mbrm_pkg::REQ_BODY)) begin
          tx_data = body_byte;
        end else if (pos == 3'(mbrm_pkg::REQ_BODY)) begin
          tx_data = crc[7:0];
        end else begin
          tx_data = crc[15:8];
          last    = 1'b1;
        end
      end
      mbrm_pkg::MODE_WORDS: begin
        if (pos < 3'(WORD_CNT)) begin
          kind       = mbrm_pkg::KIND_WORD;
          word_index = pos;
          word_value = rd_word;
          // upper words are signed percentages
          if (pos >= 3'(mbrm_pkg::CLAMP_FROM)) begin
            if (rd_word[15]) begin
              word_value = 16'd0;
            end else if (rd_word > mbrm_pkg::CLAMP_MAX) begin
              word_value = mbrm_pkg::CLAMP_MAX;
            end
          end
        end else begin
          status = mbrm_pkg::ST_OK;
          last   = 1'b1;
        end
      end
      default: begin
        status = cur.st;
        last   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (batch_load) begin
      busy <= 1'b1;
    end else if (take && last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (batch_load) begin
      cur <= batch;
      pos <= 3'd0;
      crc <= mbrm_pkg::CRC_INIT;
    end else if (take && !last) begin
      pos <= pos + 3'd1;
      if (cur.mode == mbrm_pkg::MODE_TX && pos < 3'(mbrm_pkg::REQ_BODY)) begin
        crc <= mbrm_pkg::crc_byte(crc, body_byte);
      end
    end
  end

endmodule

### src/modbus_rtu_master_transaction.sv
// Top level of the Modbus RTU master: one FC03/FC06 transaction at a time.
//
//   channel   signals                              moves
//   --------  -----------------------------------  ---------------------------------
//   in        in_valid / in_ready                  action, target_register,
//                                                  write_value, rx_data
//   out       out_valid / out_ready                kind, tx_data, word_index,
//                                                  word_value, status, last
//   cfg       psel penable pwrite paddr pwdata     slave_address @0, first_register
//             prdata pready                        @4, timeout_ms @8
//
// An accepted input is held in the input register, then the core updates the
// transaction state and hands its results to the sequencer as a run. The sequencer
// gives one result a cycle while out_ready is high: a start command yields 8 request
// bytes (the request CRC is built byte by byte as they go out), a good read reply
// yields the words then a status, any other end just a status. The next item waits
// in the input register while a run drains. Stalls on out_ready hold the current result.
// Synchronous active-high reset returns to idle with the defaults of the registers;
// the word store is not cleared and only read after it is filled by a good reply.
module modbus_rtu_master_transaction #(
  parameter int NUM_REGS = 6
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [15:0] target_register,
  input  logic [15:0] write_value,
  input  logic [7:0]  rx_data,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  tx_data,
  output logic [2:0]  word_index,
  output logic [15:0] word_value,
  output logic [2:0]  status,
  output logic        last
);

  mbrm_pkg::cfg_t    cfg;
  mbrm_pkg::batch_t  batch;
  logic              batch_load;
  logic              batch_free;
  logic [2:0]        rd_idx;
  logic [15:0]       rd_word;

  mbrm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // state update and reply checking, one item per cycle while the sequencer is free
  mbrm_core #(.NUM_REGS(NUM_REGS)) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .action          (action),
    .target_register (target_register),
    .write_value     (write_value),
    .rx_data         (rx_data),
    .batch_free      (batch_free),
    .batch_load      (batch_load),
    .batch           (batch),
    .rd_idx          (rd_idx),
    .rd_word         (rd_word)
  );

  // result run playback, one result per cycle while out_ready is high
  mbrm_seq #(.NUM_REGS(NUM_REGS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .batch_load (batch_load),
    .batch      (batch),
    .batch_free (batch_free),
    .rd_idx     (rd_idx),
    .rd_word    (rd_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .kind       (kind),
    .tx_data    (tx_data),
    .word_index (word_index),
    .word_value (word_value),
    .status     (status),
    .last       (last)
  );

endmodule

### src/mbrm_checker.sv
// Port-level assertions for the Modbus RTU master, bound to the top level.
module mbrm_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  kind,
  input logic [7:0]  tx_data,
  input logic [2:0]  word_index,
  input logic [15:0] word_value,
  input logic [2:0]  status,
  input logic        last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(tx_data)
      && $stable(word_value) && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= mbrm_pkg::KIND_STATUS)
    else $error("undefined result kind");

  a_tx_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == mbrm_pkg::KIND_TX |-> word_index == 3'd0 && word_value == 16'd0
      && status == 3'd0)
    else $error("request byte carries stray fields");

  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == mbrm_pkg::KIND_STATUS |-> last && tx_data == 8'h00
      && status <= mbrm_pkg::ST_BAD_CRC)
    else $error("status is not the closing result of its run");

endmodule

bind modbus_rtu_master_transaction mbrm_checker u_mbrm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .kind       (kind),
  .tx_data    (tx_data),
  .word_index (word_index),
  .word_value (word_value),
  .status     (status),
  .last       (last)
);
